### design/ame_pkg.sv
// Package for the accumulator machine execute unit.
// Holds opcodes, status codes, depths and controller/datapath types. No dependencies.
package ame_pkg;

   localparam int DataDepth = 1024;
   localparam int CodeDepth = 1024;
   localparam int DataAw    = $clog2(DataDepth);
   localparam int CodeAw    = $clog2(CodeDepth);

   typedef enum logic [3:0] {
      OP_LOAD  = 4'd0,  OP_CONST = 4'd1,  OP_STORE = 4'd2,  OP_ADD   = 4'd3,
      OP_SUB   = 4'd4,  OP_MUL   = 4'd5,  OP_DIV   = 4'd6,  OP_JUMP  = 4'd7,
      OP_JZERO = 4'd8,  OP_READ  = 4'd9,  OP_WRITE = 4'd10, OP_HALT  = 4'd11
   } op_type;

   typedef enum logic [2:0] {
      ST_RUN = 3'd0, ST_HALT = 3'd1, ST_BADOP = 3'd2, ST_BADADDR = 3'd3, ST_DIVZERO = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_READ, S_EXEC, S_DIV, S_DONE
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clear_we;    // write zero at the clear pointer
      logic capture;     // take the request into the datapath
      logic exec;        // compute the result from memory data
      logic div_start;   // load the divider
      logic div_step;    // one quotient bit
      logic div_finish;  // apply the quotient
      logic rsp_load;    // present the result
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clear_last;
      logic needs_div;
      logic div_last;
   } stat_type;

endpackage

### design/ame_control.sv
// Controller state machine of the accumulator machine execute unit.
// Depends on ame_pkg.
module ame_control import ame_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // State and output valid registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign req_stall = (state_ff != S_IDLE);

   // Next state and commands.
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         S_CLEAR: begin
            cmd.clear_we = 1'b1;
            if (stat.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_READ;
            end
         end
         S_READ: begin
            state_in = S_EXEC;
         end
         S_EXEC: begin
            if (stat.needs_div) begin
               cmd.div_start = 1'b1;
               state_in      = S_DIV;
            end else begin
               cmd.exec = 1'b1;
               state_in = S_DONE;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            // The previous result must be gone before this one is shown.
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

### design/ame_datapath.sv
// Datapath of the accumulator machine execute unit: accumulator, data memory,
// multiplier, serial divider and result registers. Depends on ame_pkg.
module ame_datapath import ame_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output stat_type           stat,
   input  logic [3:0]         req_operation,
   input  logic signed [31:0] req_operand,
   input  logic [9:0]         req_fetch_address,
   input  logic signed [31:0] req_read_value,
   output logic [9:0]         rsp_next_address,
   output logic [2:0]         rsp_status,
   output logic               rsp_write_valid,
   output logic signed [31:0] rsp_write_value,
   output logic signed [31:0] rsp_accumulator_out
);

   logic [31:0] mem [DataDepth];
   logic [DataAw:0] clr_ff;
   logic [31:0] mdata_ff;

   logic [3:0]  op_ff;
   logic [31:0] opnd_ff, rval_ff, acc_ff;
   logic [9:0]  fetch_ff;

   // Result staging.
   logic [9:0]  next_ff;
   logic [2:0]  status_ff;
   logic        wvalid_ff;
   logic [31:0] wvalue_ff;

   logic [9:0]  next_o_ff;
   logic [2:0]  status_o_ff;
   logic        wvalid_o_ff;
   logic [31:0] wvalue_o_ff, acc_o_ff;

   // Divider state.
   logic [31:0] dq_ff, dd_ff;
   logic [32:0] rem_ff;
   logic [5:0]  dcnt_ff;
   logic        dneg_ff;

   logic data_ok, code_ok, uses_data, valid_op, mem_we;
   logic [DataAw-1:0] maddr;
   logic [31:0] mwdata;
   logic [9:0]  seq_next;
   logic [31:0] prod;
   logic [32:0] rem_sh, rem_sub;

   assign data_ok  = opnd_ff < 32'(DataDepth);
   assign code_ok  = opnd_ff < 32'(CodeDepth);
   assign valid_op = op_ff <= OP_HALT;
   assign uses_data = op_ff == OP_LOAD || op_ff == OP_STORE || op_ff == OP_ADD ||
                      op_ff == OP_SUB || op_ff == OP_MUL || op_ff == OP_DIV ||
                      op_ff == OP_READ || op_ff == OP_WRITE;
   assign seq_next = CodeAw'(fetch_ff + 10'd1);
   assign prod     = acc_ff * mdata_ff;

   assign stat.clear_last = clr_ff == (DataAw+1)'(DataDepth - 1);
   assign stat.needs_div  = op_ff == OP_DIV && data_ok && mdata_ff != 32'd0;
   assign stat.div_last   = dcnt_ff == 6'd31;

   // Memory write: clearing sweep, store or read instruction.
   always_comb begin
      maddr  = opnd_ff[DataAw-1:0];
      mwdata = (op_ff == OP_READ) ? rval_ff : acc_ff;
      mem_we = cmd.exec && data_ok && (op_ff == OP_STORE || op_ff == OP_READ);
      if (cmd.clear_we) begin
         maddr  = clr_ff[DataAw-1:0];
         mwdata = '0;
         mem_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[maddr] <= mwdata;
      end
      mdata_ff <= mem[opnd_ff[DataAw-1:0]];
   end

   // Clear pointer.
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clear_we) begin
         clr_ff <= clr_ff + 1'b1;
      end
   end

   // Request capture.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= req_operation;
         opnd_ff  <= req_operand;
         fetch_ff <= req_fetch_address;
         rval_ff  <= req_read_value;
      end
   end

   // Restoring divider step on magnitudes.
   assign rem_sh  = {rem_ff[31:0], dq_ff[31]};
   assign rem_sub = rem_sh - {1'b0, dd_ff};

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         dq_ff   <= acc_ff[31] ? 32'(-acc_ff) : acc_ff;
         dd_ff   <= mdata_ff[31] ? 32'(-mdata_ff) : mdata_ff;
         rem_ff  <= '0;
         dcnt_ff <= '0;
         dneg_ff <= acc_ff[31] ^ mdata_ff[31];
      end else if (cmd.div_step) begin
         dcnt_ff <= dcnt_ff + 6'd1;
         if (!rem_sub[32]) begin
            rem_ff <= rem_sub;
            dq_ff  <= {dq_ff[30:0], 1'b1};
         end else begin
            rem_ff <= rem_sh;
            dq_ff  <= {dq_ff[30:0], 1'b0};
         end
      end
   end

   // Accumulator and result staging.
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else if (cmd.div_step && stat.div_last) begin
         acc_ff <= dneg_ff ? 32'(-{dq_ff[30:0], !rem_sub[32]})
                           : {dq_ff[30:0], !rem_sub[32]};
      end else if (cmd.exec && valid_op && !(uses_data && !data_ok)) begin
         case (op_type'(op_ff))
            OP_LOAD:  acc_ff <= mdata_ff;
            OP_CONST: acc_ff <= opnd_ff;
            OP_ADD:   acc_ff <= acc_ff + mdata_ff;
            OP_SUB:   acc_ff <= acc_ff - mdata_ff;
            OP_MUL:   acc_ff <= prod;
            default:  acc_ff <= acc_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         next_ff   <= seq_next;
         status_ff <= ST_RUN;
         wvalid_ff <= 1'b0;
         wvalue_ff <= '0;
      end else if (cmd.exec) begin
         next_ff   <= seq_next;
         status_ff <= ST_RUN;
         wvalid_ff <= 1'b0;
         wvalue_ff <= '0;
         if (!valid_op) begin
            status_ff <= ST_BADOP;
         end else if (uses_data && !data_ok) begin
            status_ff <= ST_BADADDR;
         end else begin
            case (op_type'(op_ff))
               OP_DIV:   status_ff <= ST_DIVZERO;
               OP_JUMP, OP_JZERO: begin
                  if (op_ff == OP_JUMP || acc_ff == 32'd0) begin
                     if (code_ok) begin
                        next_ff <= opnd_ff[CodeAw-1:0];
                     end else begin
                        status_ff <= ST_BADADDR;
                     end
                  end
               end
               OP_WRITE: begin
                  wvalid_ff <= 1'b1;
                  wvalue_ff <= mdata_ff;
               end
               OP_HALT:  status_ff <= ST_HALT;
               default:  status_ff <= ST_RUN;
            endcase
         end
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         next_o_ff   <= next_ff;
         status_o_ff <= status_ff;
         wvalid_o_ff <= wvalid_ff;
         wvalue_o_ff <= wvalue_ff;
         acc_o_ff    <= acc_ff;
      end
   end

   assign rsp_next_address    = next_o_ff;
   assign rsp_status          = status_o_ff;
   assign rsp_write_valid     = wvalid_o_ff;
   assign rsp_write_value     = wvalue_o_ff;
   assign rsp_accumulator_out = acc_o_ff;

endmodule

### design/accumulator_machine_execute.sv
// Top level of the accumulator machine execute unit.
// Depends on ame_pkg, ame_control and ame_datapath.
//
//   Channel  Ports                                                     Direction
//   request  req_valid req_stall req_operation req_operand ...          in
//   response rsp_valid rsp_stall rsp_next_address rsp_status ...        out
//
// A request passes through capture, memory read, execute and result load;
// a divide runs the one-bit-per-cycle restoring divider before the result load.
// After reset the data memory is swept to zero, one word per cycle, over all
// 1024 words; req_stall stays high during the sweep.
// A stalled response holds the next result in the done state until taken.
module accumulator_machine_execute import ame_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [3:0]         req_operation,
   input  logic signed [31:0] req_operand,
   input  logic [9:0]         req_fetch_address,
   input  logic signed [31:0] req_read_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [9:0]         rsp_next_address,
   output logic [2:0]         rsp_status,
   output logic               rsp_write_valid,
   output logic signed [31:0] rsp_write_value,
   output logic signed [31:0] rsp_accumulator_out
);

   cmd_type  cmd;
   stat_type stat;

   ame_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   ame_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .req_operation       (req_operation),
      .req_operand         (req_operand),
      .req_fetch_address   (req_fetch_address),
      .req_read_value      (req_read_value),
      .rsp_next_address    (rsp_next_address),
      .rsp_status          (rsp_status),
      .rsp_write_valid     (rsp_write_valid),
      .rsp_write_value     (rsp_write_value),
      .rsp_accumulator_out (rsp_accumulator_out)
   );

endmodule

### test/accumulator_machine_execute_tb.sv
// Self-checking testbench for the accumulator machine execute unit.
// Depends on ame_pkg and accumulator_machine_execute; predicts each response internally.
module accumulator_machine_execute_tb;
   import ame_pkg::*;

   typedef struct packed {
      logic [9:0]  next_address;
      logic [2:0]  status;
      logic        write_valid;
      logic [31:0] write_value;
      logic [31:0] accumulator_out;
   } exec_result_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [3:0]         req_operation;
   logic signed [31:0] req_operand;
   logic [9:0]         req_fetch_address;
   logic signed [31:0] req_read_value;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [9:0]         rsp_next_address;
   logic [2:0]         rsp_status;
   logic               rsp_write_valid;
   logic signed [31:0] rsp_write_value;
   logic signed [31:0] rsp_accumulator_out;

   // Shadow state of the machine.
   logic [31:0] shadow_acc;
   logic [31:0] shadow_mem [DataDepth];

   exec_result_type expected_results [$];
   int error_count;
   int cycle_count;
   int request_count;
   int response_count;
   bit stall_enable;

   localparam int CycleLimit = 2000000;

   accumulator_machine_execute u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_operation       (req_operation),
      .req_operand         (req_operand),
      .req_fetch_address   (req_fetch_address),
      .req_read_value      (req_read_value),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_next_address    (rsp_next_address),
      .rsp_status          (rsp_status),
      .rsp_write_valid     (rsp_write_valid),
      .rsp_write_value     (rsp_write_value),
      .rsp_accumulator_out (rsp_accumulator_out)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Signed division truncating toward zero, wrapping at 32 bits.
   function automatic logic [31:0] quotient_trunc(logic [31:0] a, logic [31:0] b);
      logic [31:0] ma;
      logic [31:0] mb;
      logic [31:0] q;
      ma = a[31] ? -a : a;
      mb = b[31] ? -b : b;
      q  = ma / mb;
      return (a[31] != b[31]) ? -q : q;
   endfunction

   // Executes one instruction on the shadow state and returns its response.
   function automatic exec_result_type execute_instruction(logic [3:0] op, logic [31:0] opnd,
                                                           logic [9:0] fetch, logic [31:0] rval);
      exec_result_type r;
      logic data_ok;
      logic code_ok;
      logic uses_data;
      logic [31:0] word;
      r = '0;
      r.next_address = fetch + 10'd1;
      r.status = ST_RUN;
      data_ok = opnd < DataDepth;
      code_ok = opnd < CodeDepth;
      word = data_ok ? shadow_mem[opnd[DataAw-1:0]] : 32'd0;
      uses_data = op inside {OP_LOAD, OP_STORE, OP_ADD, OP_SUB, OP_MUL, OP_DIV,
                             OP_READ, OP_WRITE};
      if (op > OP_HALT) begin
         r.status = ST_BADOP;
      end else if (uses_data && !data_ok) begin
         r.status = ST_BADADDR;
      end else begin
         case (op)
            OP_LOAD:  shadow_acc = word;
            OP_CONST: shadow_acc = opnd;
            OP_STORE: shadow_mem[opnd[DataAw-1:0]] = shadow_acc;
            OP_ADD:   shadow_acc = shadow_acc + word;
            OP_SUB:   shadow_acc = shadow_acc - word;
            OP_MUL:   shadow_acc = shadow_acc * word;
            OP_DIV: begin
               if (word == 0) r.status = ST_DIVZERO;
               else shadow_acc = quotient_trunc(shadow_acc, word);
            end
            OP_JUMP, OP_JZERO: begin
               if (op == OP_JUMP || shadow_acc == 0) begin
                  if (code_ok) r.next_address = opnd[9:0];
                  else r.status = ST_BADADDR;
               end
            end
            OP_READ:  shadow_mem[opnd[DataAw-1:0]] = rval;
            OP_WRITE: begin
               r.write_valid = 1'b1;
               r.write_value = word;
            end
            default:  r.status = ST_HALT;
         endcase
      end
      r.accumulator_out = shadow_acc;
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch on response %0d: %s got %h expected %h",
               response_count, what, got, want);
      error_count++;
   endtask

   // Sends one request, with an occasional idle gap before it.
   task automatic send_request(logic [3:0] op, logic [31:0] opnd, logic [9:0] fetch,
                               logic [31:0] rval, int gap);
      repeat (gap) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_operation     <= op;
      req_operand       <= opnd;
      req_fetch_address <= fetch;
      req_read_value    <= rval;
      do @(posedge clock); while (req_stall);
      expected_results.push_back(execute_instruction(op, opnd, fetch, rval));
      request_count++;
   endtask

   task automatic finish_stream();
      req_valid <= 1'b0;
   endtask

   // Picks a data address that is mostly in range, sometimes far outside.
   function automatic logic [31:0] random_data_address();
      case ($urandom_range(0, 9))
         0: return $urandom;
         1: return DataDepth + $urandom_range(0, 7);
         2: return -$urandom_range(1, 4);
         default: return $urandom_range(0, 15);
      endcase
   endfunction

   function automatic logic [31:0] random_value();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'hFFFF_FFFF;
         2: return $urandom_range(0, 3);
         default: return $urandom;
      endcase
   endfunction

   // Extremes of every field and each listed special case.
   task automatic test_directed();
      send_request(OP_LOAD, 32'd0, 10'd0, 32'd0, 0);
      send_request(OP_DIV, 32'd5, 10'd1, 32'd0, 0);
      send_request(OP_READ, 32'd5, 10'd2, 32'hFFFF_FFFF, 0);
      send_request(OP_CONST, 32'h8000_0000, 10'd3, 32'h0, 0);
      send_request(OP_DIV, 32'd5, 10'd4, 32'h0, 0);
      send_request(OP_READ, 32'd1023, 10'd5, 32'h7FFF_FFFF, 0);
      send_request(OP_WRITE, 32'd1023, 10'd1023, 32'h0, 0);
      send_request(OP_ADD, 32'd1023, 10'd6, 32'h0, 1);
      send_request(OP_SUB, 32'd5, 10'd7, 32'h0, 0);
      send_request(OP_MUL, 32'd1023, 10'd8, 32'h0, 0);
      send_request(OP_STORE, 32'd9, 10'd9, 32'h0, 0);
      send_request(OP_LOAD, 32'd1024, 10'd10, 32'h0, 0);
      send_request(OP_STORE, 32'hFFFF_FFFF, 10'd11, 32'h0, 0);
      send_request(OP_WRITE, 32'h8000_0000, 10'd12, 32'h0, 0);
      send_request(OP_JUMP, 32'd1023, 10'd13, 32'h0, 0);
      send_request(OP_JUMP, 32'd1024, 10'd14, 32'h0, 0);
      send_request(OP_JZERO, 32'hFFFF_FFFF, 10'd15, 32'h0, 0);
      send_request(OP_CONST, 32'd0, 10'd16, 32'h0, 0);
      send_request(OP_JZERO, 32'd512, 10'd17, 32'h0, 0);
      send_request(OP_JZERO, 32'h7FFF_FFFF, 10'd18, 32'h0, 0);
      send_request(OP_HALT, 32'hFFFF_FFFF, 10'd19, 32'hFFFF_FFFF, 0);
      for (int op = 12; op < 16; op++) begin
         send_request(op[3:0], 32'd3, 10'd20 + op[9:0], 32'h0, 0);
      end
   endtask

   // Random instruction mix driven in bursts with gaps.
   task automatic test_random(int count);
      int burst;
      int gap;
      logic [3:0] op;
      logic [31:0] opnd;
      burst = 0;
      for (int i = 0; i < count; i++) begin
         gap = 0;
         if (burst == 0) begin
            burst = $urandom_range(1, 20);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         end
         burst--;
         op = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(12, 15))
                                           : 4'($urandom_range(0, 11));
         case (op)
            OP_CONST: opnd = random_value();
            OP_JUMP, OP_JZERO:
               opnd = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 1023);
            default: opnd = random_data_address();
         endcase
         send_request(op, opnd, 10'($urandom), random_value(), gap);
      end
   endtask

   // Receiver stall pattern: alternates stalling stretches with free stretches.
   initial begin
      rsp_stall = 1'b1;
      stall_enable = 1'b0;
      @(posedge clock);
      forever begin
         if ($urandom_range(0, 3) == 0) stall_enable = ~stall_enable;
         rsp_stall <= stall_enable ? ($urandom_range(0, 2) != 0) : 1'b0;
         @(posedge clock);
      end
   end

   // Response checker.
   always @(posedge clock) begin
      exec_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            $display("unexpected response %0d", response_count);
            error_count++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_next_address !== want.next_address)
               report_mismatch("next_address", 32'(rsp_next_address),
                               32'(want.next_address));
            if (rsp_status !== want.status)
               report_mismatch("status", 32'(rsp_status), 32'(want.status));
            if (rsp_write_valid !== want.write_valid)
               report_mismatch("write_valid", 32'(rsp_write_valid), 32'(want.write_valid));
            if (rsp_write_value !== want.write_value)
               report_mismatch("write_value", rsp_write_value, want.write_value);
            if (rsp_accumulator_out !== want.accumulator_out)
               report_mismatch("accumulator_out", rsp_accumulator_out, want.accumulator_out);
         end
         response_count++;
      end
   end

   // Watchdog on total run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("** accumulator_machine_execute: FAILED **");
         $finish;
      end
   end

   initial begin
      error_count       = 0;
      cycle_count       = 0;
      request_count     = 0;
      response_count    = 0;
      shadow_acc        = '0;
      foreach (shadow_mem[i]) shadow_mem[i] = '0;
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_operation     = '0;
      req_operand       = '0;
      req_fetch_address = '0;
      req_read_value    = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(1650);
      finish_stream();
      while (expected_results.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      $display("Ran %0d requests and checked %0d responses covering all opcodes,",
               request_count, response_count);
      $display("address and divide errors, jumps and random stalls on both sides.");
      if (error_count == 0) begin
         $display("** accumulator_machine_execute: PASSED **");
      end else begin
         $display("** accumulator_machine_execute: FAILED **");
      end
      $finish;
   end

endmodule
